// ----- hdl/palr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// palr_pkg
// Beat types shared by the polyline arc-length resampler.
// ----------------------------------------------------------------------------
package palr_pkg;

  localparam int COORD_W = 32;
  localparam int STEP_W  = 16;
  localparam int POS_W   = 40;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      first_point;
  } in_beat_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x;
    logic signed [COORD_W-1:0] out_y;
    logic                      last_of_run;
    logic                      overflow;
  } out_beat_t;

endpackage
`default_nettype wire

// ----- hdl/polyline_arc_length_resampler_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// polyline_arc_length_resampler_unit
// Resamples a polyline at a fixed arc-length step, one vertex per beat.
// ----------------------------------------------------------------------------
// Vertices arrive as signed Q16.16 beats. A first vertex is passed straight
// through. For a later vertex the block squares the deltas on one 32x32
// multiplier, takes a 33-step square root, then a 17-step division by the
// step for the point count, all on one shared compare/subtract unit; each
// emitted point then costs two interpolations (multiply, add, 32-step
// divide). in_ready is high only between vertices, so a new vertex is not
// taken until the last one is through. At most MAX_POINTS points come per
// segment; further points are skipped and overflow is set on every point of
// that segment.
module polyline_arc_length_resampler_unit #(
  parameter int MAX_POINTS = 64
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  palr_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  wire                 out_ready,
  output palr_pkg::out_beat_t out_data,
  input  wire                 cfg_we,
  input  wire [15:0]          cfg_data
);
  import palr_pkg::*;

  localparam int EW = $clog2(MAX_POINTS + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SQX   = 4'd1;
  localparam logic [3:0] S_SQY   = 4'd2;
  localparam logic [3:0] S_SQSUM = 4'd3;
  localparam logic [3:0] S_SQRT  = 4'd4;
  localparam logic [3:0] S_CNT   = 4'd5;
  localparam logic [3:0] S_DIVC  = 4'd6;
  localparam logic [3:0] S_DIVE  = 4'd7;
  localparam logic [3:0] S_IMUL  = 4'd8;
  localparam logic [3:0] S_IADD  = 4'd9;
  localparam logic [3:0] S_IDIV  = 4'd10;
  localparam logic [3:0] S_EMIT  = 4'd11;

  logic [3:0]         state;
  logic [STEP_W-1:0]  step_length;
  logic               started;
  logic [31:0]        previous_x, previous_y;
  logic [31:0]        cur_x, cur_y;
  logic [POS_W-1:0]   pos, pos_new;
  logic [31:0]        ax, ay;
  logic               negx, negy;
  logic [63:0]        acc, mul_p;
  logic [65:0]        val;
  logic [33:0]        rem;
  logic [32:0]        root;
  logic [5:0]         cnt;
  logic [16:0]        dvd;
  logic [15:0]        dlow, dr;
  logic [16:0]        dq;
  logic [32:0]        ir;
  logic [31:0]        dlo, iq;
  logic [32:0]        p;
  logic [EW-1:0]      k, emit;
  logic               ovf, pass, coord;
  logic [31:0]        ox_hold, oy_hold;

  logic [STEP_W-1:0]  s_eff;
  logic [31:0]        stepq;
  logic [35:0]        su_a, su_b, su_diff;
  logic               su_ge;
  logic [31:0]        mul_a, mul_b;
  logic [32:0]        dx, dy;
  logic [17:0]        count;
  logic               rem_nz;
  logic [31:0]        a_cur, base_cur, interp;
  logic [65:0]        idvd;

  assign s_eff    = (step_length == '0) ? STEP_W'(1) : step_length;
  assign stepq    = {s_eff, 16'h0000};
  assign in_ready = (state == S_IDLE);

  assign dx = {in_data.point_x[31], in_data.point_x} - {previous_x[31], previous_x};
  assign dy = {in_data.point_y[31], in_data.point_y} - {previous_y[31], previous_y};

  // shared compare/subtract step for root and both divisions
  always_comb begin
    su_a = '0;
    su_b = '0;
    case (state)
      S_SQRT: begin
        su_a = {rem, val[65:64]};
        su_b = {1'b0, root, 2'b01};
      end
      S_DIVC: begin
        su_a = {19'd0, dr, dvd[16]};
        su_b = {20'd0, s_eff};
      end
      S_IDIV: begin
        su_a = {2'd0, ir, dlo[31]};
        su_b = {3'd0, root};
      end
      default: begin
        su_a = '0;
        su_b = '0;
      end
    endcase
  end
  assign su_ge   = (su_a >= su_b);
  assign su_diff = su_a - su_b;

  // shared multiplier
  always_comb begin
    mul_a = ax;
    mul_b = ax;
    case (state)
      S_SQY: begin
        mul_a = ay;
        mul_b = ay;
      end
      S_IMUL: begin
        mul_a = coord ? ay : ax;
        mul_b = p[31:0];
      end
      default: begin
        mul_a = ax;
        mul_b = ax;
      end
    endcase
  end

  assign a_cur    = coord ? ay : ax;
  assign base_cur = coord ? previous_y : previous_x;
  // quotient including the bit decided in the final divide step
  assign interp   = (coord ? negy : negx) ? base_cur - {iq[30:0], su_ge}
                                          : base_cur + {iq[30:0], su_ge};
  assign idvd     = 66'(mul_p) + (p[32] ? {2'b00, a_cur, 32'h0} : 66'd0)
                  + 66'(root[32:1]);
  assign rem_nz   = (dr != '0) || (dlow != '0);
  assign count    = 18'(dq) + 18'(rem_nz);

  always_ff @(posedge clk) begin
    mul_p <= 64'(mul_a) * 64'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      step_length <= STEP_W'(1);
      started     <= 1'b0;
      previous_x  <= '0;
      previous_y  <= '0;
      pos         <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) step_length <= cfg_data;
      if (out_valid && out_ready && state != S_EMIT) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur_x <= in_data.point_x;
            cur_y <= in_data.point_y;
            if (in_data.first_point || !started) begin
              previous_x <= in_data.point_x;
              previous_y <= in_data.point_y;
              ox_hold    <= in_data.point_x;
              oy_hold    <= in_data.point_y;
              pos        <= POS_W'(stepq);
              started    <= 1'b1;
              pass       <= 1'b1;
              state      <= S_EMIT;
            end else begin
              negx  <= dx[32];
              negy  <= dy[32];
              ax    <= dx[32] ? 32'(-dx) : dx[31:0];
              ay    <= dy[32] ? 32'(-dy) : dy[31:0];
              pass  <= 1'b0;
              state <= S_SQX;
            end
          end
        end
        S_SQX: state <= S_SQY;
        S_SQY: begin
          acc   <= mul_p;
          state <= S_SQSUM;
        end
        S_SQSUM: begin
          val   <= 66'(acc) + 66'(mul_p);
          rem   <= '0;
          root  <= '0;
          cnt   <= 6'd32;
          state <= S_SQRT;
        end
        S_SQRT: begin
          rem  <= su_ge ? su_diff[33:0] : su_a[33:0];
          root <= {root[31:0], su_ge};
          val  <= val << 2;
          cnt  <= cnt - 6'd1;
          if (cnt == '0) state <= S_CNT;
        end
        S_CNT: begin
          // root now holds the segment length
          if (pos < POS_W'(root)) begin
            dvd   <= 17'((root - pos[32:0]) >> 16);
            dlow  <= 16'(root - pos[32:0]);
            dr    <= '0;
            dq    <= '0;
            cnt   <= 6'd16;
            state <= S_DIVC;
          end else begin
            // no point on this segment
            pos        <= pos - POS_W'(root);
            previous_x <= cur_x;
            previous_y <= cur_y;
            state      <= S_IDLE;
          end
        end
        S_DIVC: begin
          dr  <= su_ge ? su_diff[15:0] : su_a[15:0];
          dq  <= {dq[15:0], su_ge};
          dvd <= dvd << 1;
          cnt <= cnt - 6'd1;
          if (cnt == '0) state <= S_DIVE;
        end
        S_DIVE: begin
          ovf     <= (count > 18'(MAX_POINTS));
          emit    <= (count > 18'(MAX_POINTS)) ? EW'(MAX_POINTS) : count[EW-1:0];
          pos_new <= rem_nz ? POS_W'(stepq - {dr, dlow}) : '0;
          p       <= pos[32:0];
          k       <= '0;
          coord   <= 1'b0;
          state   <= S_IMUL;
        end
        S_IMUL: state <= S_IADD;
        S_IADD: begin
          ir    <= idvd[64:32];
          dlo   <= idvd[31:0];
          iq    <= '0;
          cnt   <= 6'd31;
          state <= S_IDIV;
        end
        S_IDIV: begin
          ir  <= su_ge ? su_diff[32:0] : su_a[32:0];
          iq  <= {iq[30:0], su_ge};
          dlo <= dlo << 1;
          cnt <= cnt - 6'd1;
          if (cnt == '0) begin
            if (!coord) begin
              coord <= 1'b1;
              state <= S_IMUL;
            end else begin
              state <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            if (pass) begin
              out_data <= '{out_x: ox_hold, out_y: oy_hold,
                            last_of_run: 1'b1, overflow: 1'b0};
              state    <= S_IDLE;
            end else begin
              out_data <= '{out_x: ox_hold, out_y: oy_hold,
                            last_of_run: (k == emit - EW'(1)), overflow: ovf};
              if (k == emit - EW'(1)) begin
                pos        <= pos_new;
                previous_x <= cur_x;
                previous_y <= cur_y;
                state      <= S_IDLE;
              end else begin
                k     <= k + EW'(1);
                p     <= p + 33'(stepq);
                coord <= 1'b0;
                state <= S_IMUL;
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase
      // first interpolated coordinate is held until the second is ready
      if (state == S_IDIV && cnt == '0) begin
        if (!coord) ox_hold <= interp;
        else        oy_hold <= interp;
      end
    end
  end

endmodule
`default_nettype wire
